// File: design/nsf_pkg.sv
// Shared constants, codes and helpers for the NMEA sentence framer.
// No dependencies; imported by nsf_out_if, the top level and the testbench.
package nsf_pkg;

  localparam int unsigned FieldCntW = 5;
  localparam int unsigned KindW     = 2;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned CfgIndexW = 2;

  // Result kinds
  localparam logic [KindW-1:0] KIND_GGA = 2'd0;
  localparam logic [KindW-1:0] KIND_ZDA = 2'd1;
  localparam logic [KindW-1:0] KIND_RMC = 2'd2;
  localparam logic [KindW-1:0] KIND_UNK = 2'd3;

  // Result status codes
  localparam logic [StatusW-1:0] ST_OK          = 3'd0;
  localparam logic [StatusW-1:0] ST_CK_MISMATCH = 3'd1;
  localparam logic [StatusW-1:0] ST_FEW_FIELDS  = 3'd2;
  localparam logic [StatusW-1:0] ST_BAD_HEX     = 3'd3;
  localparam logic [StatusW-1:0] ST_UNKNOWN     = 3'd4;
  localparam logic [StatusW-1:0] ST_INTERRUPTED = 3'd5;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] CFG_GGA_MIN = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_ZDA_MIN = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_RMC_MIN = 2'd2;

  localparam logic [FieldCntW-1:0] GGA_MIN_RESET = 5'd14;
  localparam logic [FieldCntW-1:0] ZDA_MIN_RESET = 5'd6;
  localparam logic [FieldCntW-1:0] RMC_MIN_RESET = 5'd11;
  localparam logic [FieldCntW-1:0] FIELD_CNT_MAX = 5'd31;

  // Characters of interest
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_Z      = 8'h5A;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;

  typedef struct packed {
    logic       bad;
    logic [3:0] value;
  } hex_digit_t;

  // Upper-case hex digit; an invalid character decodes as zero with bad set
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    logic [7:0] diff;
    d    = '{bad: 1'b1, value: 4'd0};
    diff = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      diff = c - CH_0;
      d    = '{bad: 1'b0, value: diff[3:0]};
    end else if (c >= CH_A && c <= CH_F) begin
      diff = c - CH_A + 8'd10;
      d    = '{bad: 1'b0, value: diff[3:0]};
    end
    return d;
  endfunction

endpackage

// File: design/nsf_if.sv
// Valid/ready channel interfaces for the sentence framer: character input
// and status result. Uses nsf_pkg for field widths.
interface nsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsf_out_if import nsf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KindW-1:0]     sentence_kind;
  logic [StatusW-1:0]   status;
  logic [7:0]           computed_checksum;
  logic [7:0]           received_checksum;
  logic [FieldCntW-1:0] fields_seen;
  logic                 talker_gp;
  logic                 point_complete;

  modport source (output valid, output sentence_kind, output status,
                  output computed_checksum, output received_checksum,
                  output fields_seen, output talker_gp, output point_complete,
                  input ready);
  modport sink   (input valid, input sentence_kind, input status,
                  input computed_checksum, input received_checksum,
                  input fields_seen, input talker_gp, input point_complete,
                  output ready);
endinterface

// File: design/nmea_sentence_framer_checksum.sv
// NMEA 0183 sentence framer and checksum checker, top level.
// Depends on nsf_pkg (codes, hex decode) and nsf_if.sv (channel interfaces).
//
//  channel   dir  payload                                   transaction
//  --------  ---  ----------------------------------------  -------------------------
//  chars     in   rx_byte[7:0]                              valid & ready at clk edge
//  reports   out  kind, status, checksums, fields, flags    valid & ready at clk edge
//  cfg_*     in   cfg_index[1:0], cfg_data[4:0]             cfg_write at clk edge
//
// One character per cycle while chars is ready: each accepted byte updates the sentence state and,
// where it ends a sentence, loads the result register in that same edge.
// Results appear in the cycle after the byte that closes the sentence.
// rst (synchronous, active high) returns to hunting for '$', clears the
// ZDA-seen flag and reloads the minimum field counts.
// A stalled result holds the result register; chars stays ready while the
// result register is empty or being taken in the same cycle.
module nmea_sentence_framer_checksum
  import nsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  nsf_in_if.sink               chars,
  nsf_out_if.source            reports,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [FieldCntW-1:0] cfg_data
);

  typedef enum logic [2:0] {
    PH_HUNT, PH_TALKER, PH_TYPE, PH_FIELDS, PH_HEX1, PH_HEX2
  } phase_t;

  // Sentence state
  phase_t               phase, phase_next;
  logic [1:0]           char_pos, char_pos_next;
  logic [7:0]           xor_acc, xor_acc_next;
  logic                 talker_match, talker_match_next;
  logic [15:0]          type_chars, type_chars_next;
  logic [KindW-1:0]     kind, kind_next;
  logic [FieldCntW-1:0] field_cnt, field_cnt_next;
  logic [3:0]           hi_digit, hi_digit_next;
  logic                 hi_bad, hi_bad_next;
  logic                 zda_seen, zda_seen_next;

  // Configuration
  logic [FieldCntW-1:0] gga_min, zda_min, rmc_min;

  // Result register
  logic                 res_valid;
  logic [KindW-1:0]     res_kind;
  logic [StatusW-1:0]   res_status;
  logic [7:0]           res_xor;
  logic [7:0]           res_rx;
  logic [FieldCntW-1:0] res_fields;
  logic                 res_tgp;
  logic                 res_point;

  // Per-byte result candidate
  logic                 emit;
  logic [KindW-1:0]     e_kind;
  logic [StatusW-1:0]   e_status;
  logic [7:0]           e_xor;
  logic [7:0]           e_rx;
  logic [FieldCntW-1:0] e_fields;
  logic                 e_tgp;
  logic                 e_point;

  logic                 take;
  logic [7:0]           c;
  hex_digit_t           lo_hex;
  logic [FieldCntW-1:0] min_fields;
  logic [7:0]           rx_ck;
  logic                 talker_ok;

  // Accept a byte whenever the result register is free or draining now
  assign chars.ready = !res_valid || reports.ready;
  assign take        = chars.valid && chars.ready;
  assign c           = chars.rx_byte;
  assign lo_hex      = hex_decode(c);
  assign talker_ok   = (char_pos == 2'd0) ? (c == CH_G) : (c == CH_P);

  always_comb begin
    unique case (kind)
      KIND_GGA: min_fields = gga_min;
      KIND_ZDA: min_fields = zda_min;
      default:  min_fields = rmc_min;
    endcase
  end

  assign rx_ck = {hi_digit, lo_hex.value};

  always_comb begin
    phase_next        = phase;
    char_pos_next     = char_pos;
    xor_acc_next      = xor_acc;
    talker_match_next = talker_match;
    type_chars_next   = type_chars;
    kind_next         = kind;
    field_cnt_next    = field_cnt;
    hi_digit_next     = hi_digit;
    hi_bad_next       = hi_bad;
    zda_seen_next     = zda_seen;
    emit              = 1'b0;
    e_kind            = KIND_UNK;
    e_status          = ST_OK;
    e_xor             = xor_acc;
    e_rx              = 8'd0;
    e_fields          = field_cnt;
    e_tgp             = talker_match;
    e_point           = 1'b0;

    if (take) begin
      if (phase != PH_HUNT && c == CH_DOLLAR) begin
        // Stray '$': report the broken sentence, then restart on this byte
        emit     = 1'b1;
        e_status = ST_INTERRUPTED;
        e_kind   = (phase == PH_FIELDS || phase == PH_HEX1 || phase == PH_HEX2)
                   ? kind : KIND_UNK;
        e_tgp    = (phase == PH_TALKER) ? 1'b0 : talker_match;
      end

      if (c == CH_DOLLAR) begin
        phase_next        = PH_TALKER;
        char_pos_next     = 2'd0;
        xor_acc_next      = 8'd0;
        talker_match_next = 1'b1;
        type_chars_next   = 16'd0;
        field_cnt_next    = '0;
        hi_digit_next     = 4'd0;
        hi_bad_next       = 1'b0;
      end else begin
        unique case (phase)
          PH_HUNT: begin
            phase_next = PH_HUNT;
          end
          PH_TALKER: begin
            xor_acc_next = xor_acc ^ c;
            if (!talker_ok) talker_match_next = 1'b0;
            if (char_pos != 2'd0) begin
              phase_next    = PH_TYPE;
              char_pos_next = 2'd0;
            end else begin
              char_pos_next = 2'd1;
            end
          end
          PH_TYPE: begin
            xor_acc_next = xor_acc ^ c;
            if (char_pos != 2'd2) begin
              type_chars_next = {type_chars[7:0], c};
              char_pos_next   = char_pos + 2'd1;
            end else begin
              char_pos_next = 2'd0;
              if (type_chars == {CH_G, CH_G} && c == CH_A) begin
                kind_next  = KIND_GGA;
                phase_next = PH_FIELDS;
              end else if (type_chars == {CH_Z, CH_D} && c == CH_A) begin
                kind_next     = KIND_ZDA;
                zda_seen_next = 1'b1;
                phase_next    = PH_FIELDS;
              end else if (type_chars == {CH_R, CH_M} && c == CH_C) begin
                kind_next  = KIND_RMC;
                phase_next = PH_FIELDS;
              end else begin
                // Unknown type ends the sentence straight away
                emit       = 1'b1;
                e_kind     = KIND_UNK;
                e_status   = ST_UNKNOWN;
                e_xor      = xor_acc ^ c;
                phase_next = PH_HUNT;
              end
            end
          end
          PH_FIELDS: begin
            if (c == CH_STAR) begin
              phase_next = PH_HEX1;
            end else begin
              xor_acc_next = xor_acc ^ c;
              if (c == CH_COMMA && field_cnt != FIELD_CNT_MAX)
                field_cnt_next = field_cnt + 1'b1;
            end
          end
          PH_HEX1: begin
            hi_digit_next = lo_hex.value;
            hi_bad_next   = lo_hex.bad;
            phase_next    = PH_HEX2;
          end
          PH_HEX2: begin
            emit     = 1'b1;
            e_kind   = kind;
            e_rx     = rx_ck;
            if (field_cnt < min_fields)       e_status = ST_FEW_FIELDS;
            else if (hi_bad || lo_hex.bad)    e_status = ST_BAD_HEX;
            else if (rx_ck != xor_acc)        e_status = ST_CK_MISMATCH;
            else                              e_status = ST_OK;
            e_point    = (e_status == ST_OK) && (kind != KIND_ZDA) && zda_seen;
            phase_next = PH_HUNT;
          end
          default: begin
            phase_next = PH_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      char_pos     <= 2'd0;
      xor_acc      <= 8'd0;
      talker_match <= 1'b1;
      type_chars   <= 16'd0;
      kind         <= KIND_UNK;
      field_cnt    <= '0;
      hi_digit     <= 4'd0;
      hi_bad       <= 1'b0;
      zda_seen     <= 1'b0;
      gga_min      <= GGA_MIN_RESET;
      zda_min      <= ZDA_MIN_RESET;
      rmc_min      <= RMC_MIN_RESET;
      res_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      char_pos     <= char_pos_next;
      xor_acc      <= xor_acc_next;
      talker_match <= talker_match_next;
      type_chars   <= type_chars_next;
      kind         <= kind_next;
      field_cnt    <= field_cnt_next;
      hi_digit     <= hi_digit_next;
      hi_bad       <= hi_bad_next;
      zda_seen     <= zda_seen_next;

      if (cfg_write) begin
        case (cfg_index)
          CFG_GGA_MIN: gga_min <= cfg_data;
          CFG_ZDA_MIN: zda_min <= cfg_data;
          CFG_RMC_MIN: rmc_min <= cfg_data;
          default:     ;
        endcase
      end

      // Load a new result, or drop the old one once it has been taken
      if (emit) begin
        res_valid <= 1'b1;
      end else if (reports.ready) begin
        res_valid <= 1'b0;
      end
    end

    if (emit) begin
      res_kind   <= e_kind;
      res_status <= e_status;
      res_xor    <= e_xor;
      res_rx     <= e_rx;
      res_fields <= e_fields;
      res_tgp    <= e_tgp;
      res_point  <= e_point;
    end
  end

  assign reports.valid             = res_valid;
  assign reports.sentence_kind     = res_kind;
  assign reports.status            = res_status;
  assign reports.computed_checksum = res_xor;
  assign reports.received_checksum = res_rx;
  assign reports.fields_seen       = res_fields;
  assign reports.talker_gp         = res_tgp;
  assign reports.point_complete    = res_point;

`ifndef SYNTHESIS
  a_ok_means_match: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status == ST_OK) |-> (res_xor == res_rx))
    else $error("ok status with differing checksums");

  a_point_only_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_point) |-> (res_status == ST_OK && res_kind != KIND_ZDA))
    else $error("track point flagged on a sentence that is not a good fix");

  a_unknown_shape: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status == ST_UNKNOWN) |->
      (res_kind == KIND_UNK && res_fields == '0 && res_rx == 8'd0))
    else $error("unknown-type result carries sentence data");

  a_dollar_restarts: assert property (@(posedge clk) disable iff (rst)
    (take && c == CH_DOLLAR) |=> (phase == PH_TALKER && xor_acc == 8'd0))
    else $error("dollar did not restart the sentence");
`endif

endmodule

// File: dv/tb_nmea_sentence_framer_checksum.sv
// Self-checking testbench for nmea_sentence_framer_checksum: framed NMEA text in, one status
// report per sentence out, checked field by field against a cycle-free sentence predictor.
// Depends on nsf_pkg (codes, widths, characters) and nsf_if.sv (nsf_in_if, nsf_out_if).
module tb_nmea_sentence_framer_checksum import nsf_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // No-acceptance limit: covers the long receiver hold-off, reset and config pauses.
  localparam int StallLimit = 2000;

  typedef enum logic [2:0] {HUNT, TALKER, MNEMONIC, FIELDS, HEX_HI, HEX_LO} frame_phase_t;
  typedef enum int {CK_GOOD, CK_WRONG, CK_BAD_HI, CK_BAD_LO, CK_BAD_BOTH} ck_form_t;

  typedef struct packed {
    logic [KindW-1:0]     kind;
    logic [StatusW-1:0]   status;
    logic [7:0]           computed_ck;
    logic [7:0]           received_ck;
    logic [FieldCntW-1:0] fields;
    logic                 talker_gp;
    logic                 point;
  } report_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CfgIndexW-1:0] cfg_index;
  logic [FieldCntW-1:0] cfg_data;

  nsf_in_if  chars_if ();
  nsf_out_if reports_if ();

  nmea_sentence_framer_checksum dut (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars_if),
    .reports   (reports_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Sentence predictor state: a private copy of what the framer should hold.
  frame_phase_t         phase;
  int                   char_pos;
  logic [7:0]           xor_acc;
  logic                 gp_match;
  logic [15:0]          mnem_hist;
  logic [KindW-1:0]     sent_kind;
  logic [FieldCntW-1:0] field_cnt;
  logic [4:0]           hi_digit;
  logic                 zda_flag;
  logic [FieldCntW-1:0] min_fields [3];

  report_t    pending_reports [$];
  logic [7:0] line_buf [$];

  int  mismatches    = 0;
  int  reports_seen  = 0;
  int  traffic_bytes = 0;
  int  sink_hold_len = 0;
  bit  src_idle_on   = 1'b1;
  bit  sink_stall_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ------------------------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------------------------

  // 0..15 for an upper-case hex character, 16 for anything else
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return 5'(c - CH_0);
    if (c >= CH_A && c <= CH_F) return 5'(c - CH_A + 8'd10);
    return 5'd16;
  endfunction

  function automatic void reset_predictor();
    phase     = HUNT;
    char_pos  = 0;
    xor_acc   = 8'd0;
    gp_match  = 1'b1;
    mnem_hist = 16'd0;
    sent_kind = KIND_UNK;
    field_cnt = '0;
    hi_digit  = 5'd0;
    zda_flag  = 1'b0;
    min_fields[CFG_GGA_MIN] = GGA_MIN_RESET;
    min_fields[CFG_ZDA_MIN] = ZDA_MIN_RESET;
    min_fields[CFG_RMC_MIN] = RMC_MIN_RESET;
  endfunction

  function automatic void open_sentence();
    phase     = TALKER;
    char_pos  = 0;
    xor_acc   = 8'd0;
    gp_match  = 1'b1;
    mnem_hist = 16'd0;
    field_cnt = '0;
    hi_digit  = 5'd0;
  endfunction

  // Queue a report built from the running checksum and field count
  function automatic void note_report(input logic [KindW-1:0] kind, input logic [StatusW-1:0] st,
                                      input logic [7:0] rx_ck, input logic gp, input logic pt);
    report_t r;
    r = '{kind: kind, status: st, computed_ck: xor_acc, received_ck: rx_ck,
          fields: field_cnt, talker_gp: gp, point: pt};
    pending_reports.push_back(r);
  endfunction

  // Advance the predictor by one accepted character
  function automatic void frame_byte(input logic [7:0] c);
    logic [KindW-1:0]     kind;
    logic [4:0]           lo;
    logic [7:0]           rx;
    logic [StatusW-1:0]   st;
    logic [FieldCntW-1:0] minf;
    kind = KIND_UNK;
    if (phase == HUNT || phase > HEX_LO) begin
      if (c == CH_DOLLAR) open_sentence();
      else phase = HUNT;
      return;
    end
    // A dollar inside a sentence closes it as interrupted and opens the next one
    if (c == CH_DOLLAR) begin
      note_report(phase >= FIELDS ? sent_kind : KIND_UNK, ST_INTERRUPTED, 8'd0,
                  phase == TALKER ? 1'b0 : gp_match, 1'b0);
      open_sentence();
      return;
    end
    case (phase)
      TALKER: begin
        xor_acc ^= c;
        if (c != (char_pos == 0 ? CH_G : CH_P)) gp_match = 1'b0;
        if (char_pos >= 1) begin
          phase    = MNEMONIC;
          char_pos = 0;
        end else char_pos = 1;
      end
      MNEMONIC: begin
        xor_acc ^= c;
        if (char_pos < 2) begin
          mnem_hist = {mnem_hist[7:0], c};
          char_pos++;
        end else begin
          if (mnem_hist == {CH_G, CH_G} && c == CH_A) kind = KIND_GGA;
          else if (mnem_hist == {CH_Z, CH_D} && c == CH_A) kind = KIND_ZDA;
          else if (mnem_hist == {CH_R, CH_M} && c == CH_C) kind = KIND_RMC;
          char_pos = 0;
          if (kind == KIND_UNK) begin
            note_report(KIND_UNK, ST_UNKNOWN, 8'd0, gp_match, 1'b0);
            phase = HUNT;
          end else begin
            if (kind == KIND_ZDA) zda_flag = 1'b1;
            sent_kind = kind;
            phase     = FIELDS;
          end
        end
      end
      FIELDS: begin
        if (c == CH_STAR) phase = HEX_HI;
        else begin
          xor_acc ^= c;
          if (c == CH_COMMA && field_cnt != FIELD_CNT_MAX) field_cnt++;
        end
      end
      HEX_HI: begin
        hi_digit = digit_value(c);
        phase    = HEX_LO;
      end
      default: begin
        lo = digit_value(c);
        rx = {hi_digit[3:0], lo[3:0]};
        if (hi_digit[4]) rx[7:4] = 4'd0;
        if (lo[4]) rx[3:0] = 4'd0;
        case (sent_kind)
          KIND_GGA: minf = min_fields[CFG_GGA_MIN];
          KIND_ZDA: minf = min_fields[CFG_ZDA_MIN];
          default:  minf = min_fields[CFG_RMC_MIN];
        endcase
        // too few fields outranks a bad digit, which outranks a plain mismatch
        if (field_cnt < minf) st = ST_FEW_FIELDS;
        else if (hi_digit[4] || lo[4]) st = ST_BAD_HEX;
        else if (rx != xor_acc) st = ST_CK_MISMATCH;
        else st = ST_OK;
        note_report(sent_kind, st, rx, gp_match,
                    st == ST_OK && sent_kind != KIND_ZDA && zda_flag);
        phase = HUNT;
      end
    endcase
  endfunction

  // ------------------------------------------------------------------------------------------
  // Sentence composition
  // ------------------------------------------------------------------------------------------

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return n < 4'd10 ? 8'(CH_0 + n) : 8'(CH_A + n - 8'd10);
  endfunction

  // Any byte that is not a dollar, star or comma; mostly printable, now and then the full range
  function automatic logic [7:0] field_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 3) == 0) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(8'h20, 8'h7E));
    end while (c == CH_DOLLAR || c == CH_STAR || c == CH_COMMA);
    return c;
  endfunction

  function automatic logic [7:0] bad_digit();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (digit_value(c) != 5'd16 || c == CH_DOLLAR);
    return c;
  endfunction

  // Build "$<talker><mnemonic>{,<content>}*<hh>" into line_buf
  function automatic void compose(input string tk, input string mn, input int commas,
                                  input ck_form_t form, input int content_max);
    logic [7:0] body [$];
    logic [7:0] ck;
    body = {};
    for (int i = 0; i < 2; i++) body.push_back(tk[i]);
    for (int i = 0; i < 3; i++) body.push_back(mn[i]);
    for (int f = 0; f < commas; f++) begin
      body.push_back(CH_COMMA);
      repeat ($urandom_range(0, content_max)) body.push_back(field_char());
    end
    ck = 8'd0;
    foreach (body[i]) ck ^= body[i];
    if (form == CK_WRONG) ck ^= 8'($urandom_range(1, 255));
    line_buf.push_back(CH_DOLLAR);
    foreach (body[i]) line_buf.push_back(body[i]);
    line_buf.push_back(CH_STAR);
    line_buf.push_back(form == CK_BAD_HI || form == CK_BAD_BOTH ? bad_digit() : hex_char(ck[7:4]));
    line_buf.push_back(form == CK_BAD_LO || form == CK_BAD_BOTH ? bad_digit() : hex_char(ck[3:0]));
  endfunction

  // Cut the sentence short; the next dollar will interrupt it
  function automatic void trim_to(input int keep);
    while (line_buf.size() > keep) line_buf.delete(line_buf.size() - 1);
  endfunction

  // ------------------------------------------------------------------------------------------
  // Drivers
  // ------------------------------------------------------------------------------------------

  // Offer one character, with an occasional idle burst first; predict on acceptance
  task automatic send_byte(input logic [7:0] c);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      chars_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    chars_if.valid   <= 1'b1;
    chars_if.rx_byte <= c;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    frame_byte(c);
  endtask

  task automatic transmit_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
    traffic_bytes += line_buf.size();
    line_buf.delete();
  endtask

  // Directed sentences carry empty fields; random traffic fills them
  task automatic send_sentence(input string tk, input string mn, input int commas,
                               input ck_form_t form);
    compose(tk, mn, commas, form, 0);
    transmit_line();
  endtask

  // Drop valid, hold until every pending report is back, then let the pipeline settle
  task automatic await_reports();
    chars_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_min(input logic [CfgIndexW-1:0] idx, input logic [FieldCntW-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    min_fields[idx] = val;
    @(posedge clk);
  endtask

  task automatic set_all_mins(input logic [FieldCntW-1:0] gga, input logic [FieldCntW-1:0] zda,
                              input logic [FieldCntW-1:0] rmc);
    await_reports();
    set_min(CFG_GGA_MIN, gga);
    set_min(CFG_ZDA_MIN, zda);
    set_min(CFG_RMC_MIN, rmc);
  endtask

  // Report receiver: random stall bursts, plus a long hold-off on request
  initial begin
    reports_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (sink_hold_len > 0) begin
        reports_if.ready <= 1'b0;
        repeat (sink_hold_len) @(posedge clk);
        sink_hold_len = 0;
        reports_if.ready <= 1'b1;
      end else if (sink_stall_on && $urandom_range(0, 4) == 0) begin
        reports_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        reports_if.ready <= 1'b1;
      end else reports_if.ready <= 1'b1;
    end
  end

  // ------------------------------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch: %s on report %0d: got %0d, want %0d", what, reports_seen, got, want);
  endtask

  // Compare every accepted report with the oldest prediction
  always @(posedge clk) begin : check_reports
    report_t want;
    if (!rst && reports_if.valid && reports_if.ready) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch("report with nothing pending", 1, 0);
      end else begin
        want = pending_reports.pop_front();
        if (reports_if.sentence_kind !== want.kind)
          flag_mismatch("sentence_kind", reports_if.sentence_kind, want.kind);
        if (reports_if.status !== want.status)
          flag_mismatch("status", reports_if.status, want.status);
        if (reports_if.computed_checksum !== want.computed_ck)
          flag_mismatch("computed_checksum", reports_if.computed_checksum, want.computed_ck);
        if (reports_if.received_checksum !== want.received_ck)
          flag_mismatch("received_checksum", reports_if.received_checksum, want.received_ck);
        if (reports_if.fields_seen !== want.fields)
          flag_mismatch("fields_seen", reports_if.fields_seen, want.fields);
        if (reports_if.talker_gp !== want.talker_gp)
          flag_mismatch("talker_gp", reports_if.talker_gp, want.talker_gp);
        if (reports_if.point_complete !== want.point)
          flag_mismatch("point_complete", reports_if.point_complete, want.point);
      end
      reports_seen++;
    end
  end

  // Watchdog: end the run if no transaction moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((chars_if.valid && chars_if.ready) || (reports_if.valid && reports_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // ------------------------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------------------------

  // Reset minimums (GGA 14, ZDA 6, RMC 11): every status but interrupted, sticky ZDA, saturation, noise
  task automatic test_default_minimums();
    send_byte(8'h00);                             // noise outside a sentence is ignored
    send_byte(8'hFF);
    send_sentence("GP", "GGA", 14, CK_GOOD);      // ok, no ZDA yet so no track point
    send_sentence("GP", "GGA", 13, CK_GOOD);      // one field short
    send_sentence("GP", "RMC", 11, CK_WRONG);     // checksum mismatch
    send_sentence("GP", "ZDA", 6, CK_GOOD);       // ok, arms the ZDA flag
    send_sentence("GP", "RMC", 11, CK_GOOD);      // ok, completes a track point
    send_sentence("GP", "GGA", 14, CK_GOOD);      // likewise for GGA
    send_sentence("GP", "RMC", 12, CK_BAD_HI);    // bad high digit
    send_sentence("GP", "GGA", 15, CK_BAD_LO);    // bad low digit
    send_sentence("GP", "ZDA", 7, CK_BAD_BOTH);
    send_sentence("GP", "RMC", 5, CK_BAD_HI);     // too few fields outranks a bad digit
    send_sentence("GP", "GGA", 40, CK_GOOD);      // field count saturates
    send_sentence("GN", "ZDA", 6, CK_GOOD);       // other talker
    send_sentence("GP", "XYZ", 2, CK_GOOD);       // unknown type ends at the third letter
    send_sentence("PG", "GGB", 0, CK_GOOD);       // near miss, swapped talker
  endtask

  // A stray dollar in each phase of a sentence; the dollar itself opens the next one
  task automatic test_stray_dollar();
    int full;
    int cuts [7];
    compose("GP", "GGA", 2, CK_GOOD, 0);
    full = line_buf.size();
    line_buf.delete();
    // talker (two cuts), type, fields, after a comma, high digit, low digit
    cuts = '{1, 2, 4, 6, 7, full - 2, full - 1};
    foreach (cuts[i]) begin
      compose("GP", "GGA", 2, CK_GOOD, 0);
      trim_to(cuts[i]);
      transmit_line();
    end
    send_sentence("GP", "ZDA", 6, CK_GOOD);
  endtask

  // Hold the receiver off while sentences keep coming, then pause until all reports are in
  task automatic test_backpressure();
    await_reports();
    sink_hold_len = 150;
    repeat (3) begin
      send_sentence("GP", "QQQ", 1, CK_GOOD);
      send_sentence("GP", "ZDA", 6, CK_GOOD);
    end
    await_reports();
  endtask

  task automatic test_extreme_minimums();
    set_all_mins(5'd1, 5'd1, 5'd1);
    send_sentence("GP", "GGA", 1, CK_GOOD);
    send_sentence("GP", "ZDA", 0, CK_GOOD);       // no comma at all: zero fields
    send_sentence("GP", "RMC", 1, CK_BAD_LO);
    set_all_mins(FIELD_CNT_MAX, FIELD_CNT_MAX, FIELD_CNT_MAX);
    send_sentence("GP", "GGA", 31, CK_GOOD);
    send_sentence("GP", "ZDA", 30, CK_GOOD);
    send_sentence("GP", "RMC", 33, CK_WRONG);
  endtask

  function automatic logic [FieldCntW-1:0] pick_min();
    case ($urandom_range(0, 9))
      0:       return 5'd1;
      1:       return FIELD_CNT_MAX;
      default: return 5'($urandom_range(1, 8));
    endcase
  endfunction

  // One random sentence: mostly well formed, some broken, cut short, unknown or plain noise
  task automatic random_sentence();
    string                tk;
    string                mn;
    logic [FieldCntW-1:0] m;
    int                   commas;
    int                   r;
    ck_form_t             form;
    tk = "GP";
    mn = "GGA";
    if ($urandom_range(0, 99) < 6) begin
      repeat ($urandom_range(1, 5)) send_byte(field_char());
      return;
    end
    if ($urandom_range(0, 9) >= 7) begin
      for (int i = 0; i < 2; i++)
        tk.putc(i, $urandom_range(0, 3) == 0 ? field_char() : 8'($urandom_range(CH_A, CH_Z)));
    end
    r = $urandom_range(0, 19);
    if (r < 6) begin
      mn = "GGA";
      m  = min_fields[CFG_GGA_MIN];
    end else if (r < 12) begin
      mn = "ZDA";
      m  = min_fields[CFG_ZDA_MIN];
    end else if (r < 18) begin
      mn = "RMC";
      m  = min_fields[CFG_RMC_MIN];
    end else begin
      // unknown: a one-letter miss of a known type, or three random letters
      mn = r == 18 ? "RMC" : "ZDA";
      mn.putc($urandom_range(0, 2), 8'($urandom_range(CH_A, CH_Z)));
      if ($urandom_range(0, 1) == 0)
        for (int i = 0; i < 3; i++) mn.putc(i, 8'($urandom_range(CH_A, CH_Z)));
      m = 5'd2;
    end
    r      = $urandom_range(0, 4);
    commas = int'(m) + r - 2;
    if ($urandom_range(0, 7) == 0) commas = $urandom_range(0, m);
    if (commas < 0) commas = 0;
    r = $urandom_range(0, 19);
    case (r)
      13, 14:  form = CK_WRONG;
      15:      form = CK_BAD_HI;
      16:      form = CK_BAD_LO;
      17:      form = CK_BAD_BOTH;
      default: form = CK_GOOD;
    endcase
    compose(tk, mn, commas, form, m > 12 ? 0 : 2);
    if (r >= 18) trim_to($urandom_range(1, line_buf.size() - 1));
    transmit_line();
  endtask

  // Random sentences under changing minimums; the last stretch runs with no idling at all
  task automatic test_random_traffic();
    int sentences;
    sentences     = 0;
    traffic_bytes = 0;
    while (traffic_bytes < 290) begin
      if (sentences % 12 == 0) begin
        src_idle_on   = $urandom_range(0, 2) != 0;
        sink_stall_on = $urandom_range(0, 2) != 0;
        set_all_mins(pick_min(), pick_min(), pick_min());
      end
      if (traffic_bytes > 190) begin
        src_idle_on   = 1'b0;
        sink_stall_on = 1'b0;
      end
      random_sentence();
      sentences++;
    end
  endtask

  initial begin
    rst              <= 1'b1;
    chars_if.valid   <= 1'b0;
    chars_if.rx_byte <= 8'd0;
    cfg_write        <= 1'b0;
    cfg_index        <= CFG_GGA_MIN;
    cfg_data         <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    reset_predictor();

    test_default_minimums();
    test_stray_dollar();
    test_backpressure();
    test_extreme_minimums();
    test_random_traffic();

    // Drain, then wait so that the result register can show anything unexpected
    await_reports();
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
